@@ hw/rtl/bfba_pkg.sv @@
// Types, constants and state codes shared by the best-fit allocator modules.
`timescale 1ns / 1ps

package bfba_pkg;

	// Table geometry
	localparam int NUM_BLOCKS = 16;
	localparam int SIZE_BITS  = 16;
	localparam int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

	// Fixed field widths of the item ports
	localparam int SLOT_W  = 4;
	localparam int VAL_W   = 16;
	localparam int COUNT_W = 5;

	// Width used to compare a cell index against the block count and a slot against the table size
	localparam int CMP_W = ((IDX_W + 1) > COUNT_W) ? (IDX_W + 1) : COUNT_W;

	// Request type codes
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_ALLOC = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [SLOT_W-1:0] block_slot;
		logic [VAL_W-1:0]  size_value;
	} req_item_t;

	typedef struct packed {
		logic              granted;
		logic [SLOT_W-1:0] chosen_block;
		logic [VAL_W-1:0]  size_before;
		logic [VAL_W-1:0]  size_after;
	} rsp_item_t;

	// Table write broadcast to all cells
	typedef struct packed {
		logic                 en;
		logic [IDX_W-1:0]     idx;
		logic [SIZE_BITS-1:0] data;
	} wr_t;

	// Scan record handed from cell to cell
	typedef struct packed {
		logic                 active;
		logic                 found;
		logic [IDX_W-1:0]     best_idx;
		logic [SIZE_BITS-1:0] best_size;
		logic [SIZE_BITS-1:0] req_size;
		logic [COUNT_W-1:0]   limit;
	} scan_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

@@ hw/rtl/best_fit_block_allocator.sv @@
// Best-fit block allocator: top level with the cell chain, control and result register.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------
//  req     | in        | req_valid / req_stall   | req_item_t (type, slot, size)
//  rsp     | out       | rsp_valid / rsp_stall   | rsp_item_t (grant, block, sizes)
//  cfg     | in        | cfg_wr_en               | cfg_wr_data (block count)
//
// A load writes the entry at the transfer and registers the echo.
// An allocate walks the scan record down the chain of cells one entry per cycle, then
// captures the winner and, once the result register is free, writes back and registers the result.
// One item is in work at a time; a result waiting under rsp_stall holds back the next one.
// Reset clears the table to zero and the block count to zero.
`timescale 1ns / 1ps

module best_fit_block_allocator (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  bfba_pkg::req_item_t                req,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output bfba_pkg::rsp_item_t                rsp,
	input  logic                               cfg_wr_en,
	input  logic [bfba_pkg::COUNT_W-1:0]       cfg_wr_data
);
	import bfba_pkg::*;

	state_t               state_q;
	state_t               state_nxt;
	logic [COUNT_W-1:0]   block_count_q;
	scan_t                scan_head;
	scan_t                scan_chain [0:NUM_BLOCKS];
	wr_t                  wr;
	logic                 req_xfer;
	logic                 out_free;
	logic                 slot_ok;
	logic                 done_go;
	logic [SIZE_BITS-1:0] req_size;
	logic [SIZE_BITS-1:0] req_q;
	logic                 res_found_q;
	logic [IDX_W-1:0]     res_idx_q;
	logic [SIZE_BITS-1:0] res_before_q;
	logic [SIZE_BITS-1:0] res_after;
	logic                 rsp_valid_q;
	rsp_item_t            rsp_q;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= '0;
		end else if (cfg_wr_en) begin
			block_count_q <= cfg_wr_data;
		end
	end

	// Handshake terms
	always_comb begin
		out_free = !rsp_valid_q || !rsp_stall;
		req_xfer = req_valid && !req_stall;
		req_size = SIZE_BITS'(req.size_value);
		slot_ok  = (CMP_W'(req.block_slot) < CMP_W'(NUM_BLOCKS));
		done_go  = (state_q == ST_DONE) && out_free;
		res_after = res_before_q - req_q;
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_xfer && (req.req_type == REQ_ALLOC)) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_chain[NUM_BLOCKS].active) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Control outputs: stall, scan launch and table write
	always_comb begin
		req_stall = (state_q != ST_IDLE) || !out_free;

		scan_head          = '0;
		scan_head.active   = req_xfer && (req.req_type == REQ_ALLOC);
		scan_head.req_size = req_size;
		scan_head.limit    = block_count_q;

		wr = '0;
		if (req_xfer && (req.req_type == REQ_LOAD) && slot_ok) begin
			wr.en   = 1'b1;
			wr.idx  = IDX_W'(req.block_slot);
			wr.data = req_size;
		end else if (done_go && res_found_q) begin
			wr.en   = 1'b1;
			wr.idx  = res_idx_q;
			wr.data = res_after;
		end
	end

	assign scan_chain[0] = scan_head;

	// Chain of cells, one per table entry
	for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
		bfba_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(g)),
			.wr       (wr),
			.scan_in  (scan_chain[g]),
			.scan_out (scan_chain[g+1])
		);
	end

	// Request size and scan winner
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			req_q <= req_size;
		end
		if ((state_q == ST_SCAN) && scan_chain[NUM_BLOCKS].active) begin
			res_found_q  <= scan_chain[NUM_BLOCKS].found;
			res_idx_q    <= scan_chain[NUM_BLOCKS].best_idx;
			res_before_q <= scan_chain[NUM_BLOCKS].best_size;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((req_xfer && (req.req_type == REQ_LOAD)) || done_go) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (req_xfer && (req.req_type == REQ_LOAD)) begin
			rsp_q.granted      <= 1'b0;
			rsp_q.chosen_block <= req.block_slot;
			rsp_q.size_before  <= slot_ok ? VAL_W'(req_size) : '0;
			rsp_q.size_after   <= slot_ok ? VAL_W'(req_size) : '0;
		end else if (done_go) begin
			if (res_found_q) begin
				rsp_q.granted      <= 1'b1;
				rsp_q.chosen_block <= SLOT_W'(res_idx_q);
				rsp_q.size_before  <= VAL_W'(res_before_q);
				rsp_q.size_after   <= VAL_W'(res_after);
			end else begin
				rsp_q <= '0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ hw/rtl/bfba_cell.sv @@
// One table entry of the allocator with its stage of the best-fit scan chain.
`timescale 1ns / 1ps

module bfba_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [bfba_pkg::IDX_W-1:0]        cell_idx,
	input  bfba_pkg::wr_t                     wr,
	input  bfba_pkg::scan_t                   scan_in,
	output bfba_pkg::scan_t                   scan_out
);
	import bfba_pkg::*;

	logic [SIZE_BITS-1:0] entry_q;
	scan_t                scan_q;
	logic                 in_range;
	logic                 fits;
	logic                 better;
	logic                 take;

	// Entry storage, written by loads and by grant updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (wr.en && (wr.idx == cell_idx)) begin
			entry_q <= wr.data;
		end
	end

	// Does this entry beat the best candidate seen so far
	always_comb begin
		in_range = CMP_W'(cell_idx) < CMP_W'(scan_in.limit);
		fits     = entry_q >= scan_in.req_size;
		better   = !scan_in.found || (entry_q < scan_in.best_size);
		take     = scan_in.active && in_range && fits && better;
	end

	// Pass the scan record on to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else begin
			scan_q <= scan_in;
			if (take) begin
				scan_q.found     <= 1'b1;
				scan_q.best_idx  <= cell_idx;
				scan_q.best_size <= entry_q;
			end
		end
	end

	assign scan_out = scan_q;

endmodule

@@ verif/bfba_result_checker.sv @@
// Result checker for the best-fit block allocator: tracks transfers, predicts and compares.
`timescale 1ns / 1ps

module bfba_result_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	input  logic                         req_stall,
	input  bfba_pkg::req_item_t          req,
	input  logic                         rsp_valid,
	input  logic                         rsp_stall,
	input  bfba_pkg::rsp_item_t          rsp,
	input  logic                         cfg_wr_en,
	input  logic [bfba_pkg::COUNT_W-1:0] cfg_wr_data,
	output int                           fail_count,
	output int                           pending_count
);
	import bfba_pkg::*;

	// Shadow of the free size table and the block count
	logic [SIZE_BITS-1:0] free_sizes [NUM_BLOCKS];
	logic [COUNT_W-1:0]   scan_count;
	rsp_item_t            expected_q [$];

	// Best-fit lookup on the shadow table; updates the table like the block does
	task automatic best_fit_outcome(input req_item_t item, output rsp_item_t res);
		int                   lim;
		int                   best;
		logic                 found;
		logic [SIZE_BITS-1:0] want;
		logic [SIZE_BITS-1:0] cur;
		want  = SIZE_BITS'(item.size_value);
		res   = '0;
		found = 1'b0;
		best  = 0;
		if (item.req_type == REQ_LOAD) begin
			res.chosen_block = item.block_slot;
			// slots past the table write nothing and echo zero
			if (int'(item.block_slot) < NUM_BLOCKS) begin
				free_sizes[item.block_slot] = want;
				res.size_before = VAL_W'(want);
				res.size_after  = VAL_W'(want);
			end
		end else begin
			lim = (int'(scan_count) > NUM_BLOCKS) ? NUM_BLOCKS : int'(scan_count);
			for (int j = 0; j < lim; j++) begin
				if (free_sizes[j] >= want && (!found || free_sizes[j] < free_sizes[best])) begin
					best  = j;
					found = 1'b1;
				end
			end
			if (found) begin
				cur              = free_sizes[best];
				free_sizes[best] = cur - want;
				res.granted      = 1'b1;
				res.chosen_block = SLOT_W'(best);
				res.size_before  = VAL_W'(cur);
				res.size_after   = VAL_W'(cur - want);
			end
		end
	endtask

	// Transfer monitor: config writes, accepted requests, accepted results
	always @(posedge clk or negedge arst_n) begin
		rsp_item_t want;
		if (!arst_n) begin
			for (int j = 0; j < NUM_BLOCKS; j++)
				free_sizes[j] = '0;
			scan_count = '0;
			expected_q.delete();
			fail_count    = 0;
			pending_count = 0;
		end else begin
			if (cfg_wr_en)
				scan_count = cfg_wr_data;
			if (req_valid && !req_stall) begin
				best_fit_outcome(req, want);
				expected_q.push_back(want);
			end
			if (rsp_valid && !rsp_stall) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result g=%0d blk=%0d before=%0h after=%0h", $time,
						rsp.granted, rsp.chosen_block, rsp.size_before, rsp.size_after);
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					if (rsp.granted !== want.granted || rsp.chosen_block !== want.chosen_block ||
						rsp.size_before !== want.size_before ||
						rsp.size_after !== want.size_after) begin
						$display("%0t: expected g=%0d blk=%0d before=%0h after=%0h, actual g=%0d blk=%0d before=%0h after=%0h",
							$time, want.granted, want.chosen_block, want.size_before,
							want.size_after, rsp.granted, rsp.chosen_block, rsp.size_before,
							rsp.size_after);
						fail_count++;
					end
				end
			end
			pending_count = expected_q.size();
		end
	end

endmodule

@@ verif/best_fit_block_allocator_tb.sv @@
// Testbench top for the best-fit block allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module best_fit_block_allocator_tb;
	import bfba_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASE_ITEMS  = 250;
	localparam int HOLD_CYCLES  = 400;
	localparam int END_CYCLES   = 40;

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                req_valid   = 1'b0;
	logic                req_stall;
	req_item_t           req         = '0;
	logic                rsp_valid;
	logic                rsp_stall   = 1'b0;
	rsp_item_t           rsp;
	logic                cfg_wr_en   = 1'b0;
	logic [COUNT_W-1:0]  cfg_wr_data = '0;

	int                  fail_count;
	int                  pending_count;
	int                  cycle_count;
	int                  cur_count   = 0;
	bit                  quiet       = 1'b0;
	bit                  long_hold   = 1'b0;

	best_fit_block_allocator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	bfba_result_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req           (req),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.rsp           (rsp),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	always #1 clk = ~clk;

	// Watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[best_fit_block_allocator] ERROR");
		$finish;
	end

	// Result side backpressure: random bursts, long hold-offs on request
	always begin
		@(posedge clk);
		if (long_hold) begin
			rsp_stall <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			rsp_stall <= 1'b0;
			long_hold = 1'b0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			rsp_stall <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			rsp_stall <= 1'b0;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	function automatic req_item_t make_item(input logic kind, input logic [SLOT_W-1:0] slot,
		input logic [VAL_W-1:0] size);
		req_item_t it;
		it.req_type   = kind;
		it.block_slot = slot;
		it.size_value = size;
		return it;
	endfunction

	// Random size limited to the low bits, so loads and requests land near each other
	function automatic logic [VAL_W-1:0] scaled_size(input int bits);
		logic [31:0] mask;
		mask = (32'd1 << bits) - 32'd1;
		return VAL_W'($urandom & mask);
	endfunction

	// Load slot, mostly inside the scanned range
	function automatic logic [SLOT_W-1:0] pick_slot();
		int lim;
		lim = (cur_count > NUM_BLOCKS) ? NUM_BLOCKS : cur_count;
		if (lim > 0 && $urandom_range(0, 3) != 0)
			return SLOT_W'($urandom_range(0, lim - 1));
		return SLOT_W'($urandom);
	endfunction

	// One request transfer, with an optional idle burst ahead of it
	task automatic send_item(input req_item_t it);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= it;
		do
			@(negedge clk);
		while (req_stall);
		@(posedge clk);
	endtask

	// Stop offering and wait for every outstanding result
	task automatic wait_all_results();
		req_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_count != 0);
		@(posedge clk);
	endtask

	// Block count write, only with the block idle
	task automatic set_block_count(input int value);
		wait_all_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= COUNT_W'(value);
		cur_count    = value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	initial begin
		int phase_counts [8];
		int phase_items;
		int bits;
		int n;
		logic [31:0] raw;

		phase_counts = '{16, 31, 0, 1, $urandom_range(0, 31), 16, 8, $urandom_range(0, 31)};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Block count zero after reset: nothing is granted
		send_item(make_item(REQ_ALLOC, 4'h0, 16'h0000));
		send_item(make_item(REQ_LOAD, 4'h3, 16'd100));
		send_item(make_item(REQ_ALLOC, 4'h0, 16'd50));

		// Full table: extremes, ties, exact fit, zero-size request
		set_block_count(NUM_BLOCKS);
		send_item(make_item(REQ_LOAD, 4'h0, 16'hFFFF));
		send_item(make_item(REQ_LOAD, 4'hF, 16'hFFFF));
		send_item(make_item(REQ_LOAD, 4'h5, 16'h00FF));
		send_item(make_item(REQ_LOAD, 4'h9, 16'h00FF));
		send_item(make_item(REQ_ALLOC, 4'h0, 16'h0080));
		send_item(make_item(REQ_ALLOC, 4'h0, 16'h007F));
		send_item(make_item(REQ_ALLOC, 4'h0, 16'h0000));
		send_item(make_item(REQ_ALLOC, 4'h0, 16'hFFFF));
		send_item(make_item(REQ_ALLOC, 4'h0, 16'hFFFF));
		send_item(make_item(REQ_ALLOC, 4'h0, 16'hFFFF));
		send_item(make_item(REQ_ALLOC, 4'hF, 16'h0001));
		send_item(make_item(REQ_LOAD, 4'hF, 16'hAAAA));
		send_item(make_item(REQ_LOAD, 4'hA, 16'h5555));

		// Count past the table saturates
		set_block_count(31);
		send_item(make_item(REQ_ALLOC, 4'h0, 16'h5000));
		send_item(make_item(REQ_ALLOC, 4'h0, 16'hAAAA));

		// Single entry scan
		set_block_count(1);
		send_item(make_item(REQ_ALLOC, 4'h0, 16'h0001));
		send_item(make_item(REQ_LOAD, 4'h0, 16'd7));
		send_item(make_item(REQ_ALLOC, 4'h0, 16'd8));
		send_item(make_item(REQ_ALLOC, 4'h0, 16'd7));

		// Random phases: load groups followed by requests of a similar scale, some noise
		for (int ph = 0; ph < 8; ph++) begin
			quiet = (ph == 7);
			set_block_count(phase_counts[ph]);
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				if (ph == 1 && phase_items >= 20 && phase_items < 24)
					long_hold = 1'b1;
				if ($urandom_range(0, 99) < 85) begin
					bits = $urandom_range(1, VAL_W);
					n = $urandom_range(1, 4);
					repeat (n) begin
						send_item(make_item(REQ_LOAD, pick_slot(), scaled_size(bits)));
						phase_items++;
					end
					n = $urandom_range(1, 4);
					repeat (n) begin
						send_item(make_item(REQ_ALLOC, SLOT_W'($urandom), scaled_size(bits)));
						phase_items++;
					end
				end else begin
					raw = $urandom;
					send_item(req_item_t'(raw[$bits(req_item_t)-1:0]));
					phase_items++;
				end
			end
		end

		wait_all_results();
		repeat (END_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_count == 0) begin
			$display("[best_fit_block_allocator] OK");
		end else begin
			$display("[best_fit_block_allocator] ERROR");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/bfba_pkg.sv
hw/rtl/bfba_cell.sv
hw/rtl/best_fit_block_allocator.sv
verif/bfba_result_checker.sv
verif/best_fit_block_allocator_tb.sv
